// File: rtl/whmh_pkg.sv
// ----------------------------------------------------------------------------
// whmh_pkg
// Shared types and constants of the streaming 64-bit message hash unit.
// ----------------------------------------------------------------------------
package whmh_pkg;

  localparam logic [63:0] MIX_K           = 64'h60bee2bee120fc15;
  localparam int          LENGTH_BITS_DEF = 32;
  localparam int          BLOCK_WORDS     = 6;
  localparam int          SHORT_MAX       = 16;
  localparam int          ADDR_W          = 1;
  localparam logic [ADDR_W-1:0] ADDR_SEED = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PRE,
    ST_BLK0,
    ST_BLK1,
    ST_BLK2,
    ST_PREP,
    ST_TAIL,
    ST_FIN1,
    ST_FIN2,
    ST_OUT
  } state_e;

endpackage

// File: rtl/whmh_in_if.sv
// ----------------------------------------------------------------------------
// whmh_in_if
// Message word channel: valid/ready handshake with word, byte count and end flag.
// ----------------------------------------------------------------------------
interface whmh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;

  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

// File: rtl/whmh_out_if.sv
// ----------------------------------------------------------------------------
// whmh_out_if
// Hash result channel: valid/ready handshake with hash value and overflow flag.
// ----------------------------------------------------------------------------
interface whmh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  logic        too_long;

  modport source (output valid, hash_value, too_long, input ready);
  modport sink (input valid, hash_value, too_long, output ready);
endinterface

// File: rtl/whmh_mix.sv
// ----------------------------------------------------------------------------
// whmh_mix
// Iterative 64x64 folding multiply: one 32x32 partial product per cycle,
// accumulated into a 128-bit sum; the result is high half XOR low half.
// ----------------------------------------------------------------------------
module whmh_mix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  input  logic [63:0] y_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [63:0]  x_q, y_q;
  logic [63:0]  pp_q;
  logic [127:0] acc_q;
  logic [2:0]   step_q;
  logic [1:0]   pk_q;
  logic         run_q, done_q;
  logic [31:0]  xs, ys;
  logic [6:0]   sh;

  assign xs = step_q[1] ? x_q[63:32] : x_q[31:0];
  assign ys = step_q[0] ? y_q[63:32] : y_q[31:0];
  assign sh = (pk_q == 2'd0) ? 7'd0 : ((pk_q == 2'd3) ? 7'd64 : 7'd32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (run_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'd4) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      acc_q <= '0;
    end else if (run_q) begin
      if (step_q < 3'd4) begin
        pp_q <= xs * ys;
        pk_q <= step_q[1:0];
      end
      if (step_q != 3'd0) begin
        acc_q <= acc_q + (128'(pp_q) << sh);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q[127:64] ^ acc_q[63:0];

endmodule

// File: rtl/wyhash_variant_message_hash_unit.sv
// ----------------------------------------------------------------------------
// wyhash_variant_message_hash_unit
// Streaming 64-bit message hash with a seed register on an APB-style port.
// ----------------------------------------------------------------------------
// Words are taken one at a time; every 64x64 mix runs on one shared iterative
// multiplier. A word is loaded and then takes one mix if it is the first word of a
// message, three mixes when it completes a 48-byte block, and on the final word
// a preparation step on the long path and two or three mixes before the hash is
// presented. A finished hash waits in an output register while the next message
// word is already accepted.
module wyhash_variant_message_hash_unit #(
  parameter int LENGTH_BITS = whmh_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  whmh_in_if.sink                     msg_i,
  whmh_out_if.source                  hash_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [whmh_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);

  whmh_pkg::state_e state_q, state_d;

  logic [63:0]            seed_q, c0_q, c1_q, c2_q, r_q, cur_q, prev_q;
  logic [63:0]            st_q [whmh_pkg::BLOCK_WORDS];
  logic [2:0]             slot_q;
  logic [LENGTH_BITS-1:0] len_q;
  logic                   ovf_q, last_q, full_q, pre_q, pend_q;
  logic [3:0]             n_q;
  logic [5:0]             rem_q;
  logic                   out_valid_q, out_long_q;
  logic [63:0]            out_hash_q;

  logic                   accept, short_path, mix_op, mix_start, mix_done;
  logic [63:0]            mix_x, mix_y, mix_res;
  logic [3:0]             n_in;
  logic [63:0]            word_in;
  logic [2:0]             slot_in;
  logic [LENGTH_BITS:0]   len_sum;
  logic [7:0]             ln;
  logic [31:0]            rd04, rdl4, rdmid, xmid;
  logic [63:0]            a_s, b_s, a_l, b_l, last8, len64;
  logic [127:0]           pair;
  whmh_pkg::state_e       fin_st, after_pre;

  assign pready = 1'b1;
  assign prdata = (paddr == whmh_pkg::ADDR_SEED) ? seed_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (psel && penable && pwrite && (paddr == whmh_pkg::ADDR_SEED)) begin
      seed_q <= pwdata;
    end
  end

  assign msg_i.ready = (state_q == whmh_pkg::ST_IDLE);
  assign accept      = msg_i.valid && msg_i.ready;

  assign n_in    = !msg_i.last_word ? 4'd8 : (msg_i.byte_count > 4'd8 ? 4'd8 : msg_i.byte_count);
  assign word_in = (n_in == 4'd8) ? msg_i.data_word
                 : msg_i.data_word & ((64'd1 << {n_in[2:0], 3'b000}) - 64'd1);
  assign slot_in = (slot_q > 3'd5) ? 3'd0 : slot_q;
  assign len_sum = {1'b0, len_q} + (LENGTH_BITS + 1)'(n_in);

  assign ln    = len_q[7:0];
  assign len64 = 64'(len_q);
  assign short_path = (len_q <= LENGTH_BITS'(whmh_pkg::SHORT_MAX)) && !ovf_q;

  assign rd04  = st_q[0][31:0];
  assign rdl4  = 32'(st_q[0] >> {3'(ln - 8'd4), 3'b000});
  assign rdmid = 32'(st_q[0] >> {ln[2:1], 3'b000});
  assign xmid  = (ln <= 8'd4) ? 32'(ln) : rdl4;

  always_comb begin
    if (ln >= 8'd4 && ln <= 8'd8) begin
      a_s = {rd04, 32'd0} | ({32'd0, xmid} << 16) | {32'd0, rdmid};
    end else begin
      a_s = st_q[0];
    end
    if (ln <= 8'd8) begin
      b_s = {ln, 56'd0} | ({32'd0, rd04} << 16);
    end else begin
      b_s = st_q[1];
    end
  end

  assign pair  = {cur_q, prev_q} >> {n_q, 3'b000};
  assign last8 = pair[63:0];

  always_comb begin
    if (rem_q > 6'd16) begin
      a_l = (rem_q >= 6'd24) ? st_q[2] : st_q[0];
      b_l = (rem_q >= 6'd24) ? last8 : st_q[1];
    end else if (rem_q >= 6'd8) begin
      a_l = st_q[0];
      b_l = last8;
    end else begin
      a_l = 64'(rem_q);
      b_l = 64'(rem_q);
    end
  end

  always_comb begin
    mix_op = 1'b1;
    mix_x  = '0;
    mix_y  = '0;
    unique case (state_q)
      whmh_pkg::ST_PRE: begin
        mix_x = seed_q ^ whmh_pkg::MIX_K;
        mix_y = seed_q;
      end
      whmh_pkg::ST_BLK0: begin
        mix_x = st_q[0] ^ c0_q;
        mix_y = st_q[1] ^ c1_q;
      end
      whmh_pkg::ST_BLK1: begin
        mix_x = st_q[2] ^ c1_q;
        mix_y = st_q[3] ^ c2_q;
      end
      whmh_pkg::ST_BLK2: begin
        mix_x = st_q[4] ^ c2_q;
        mix_y = st_q[5] ^ c0_q;
      end
      whmh_pkg::ST_TAIL: begin
        mix_x = st_q[0] ^ c0_q;
        mix_y = st_q[1] ^ c2_q;
      end
      whmh_pkg::ST_FIN1: begin
        mix_x = short_path ? (a_s ^ whmh_pkg::MIX_K) : (a_l ^ c0_q);
        mix_y = short_path ? (b_s ^ c0_q) : (b_l ^ c2_q);
      end
      whmh_pkg::ST_FIN2: begin
        mix_x = r_q ^ len64;
        mix_y = short_path ? (c0_q ^ whmh_pkg::MIX_K) : whmh_pkg::MIX_K;
      end
      default: begin
        mix_op = 1'b0;
      end
    endcase
  end

  assign mix_start = mix_op && !pend_q;

  whmh_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mix_start),
    .x_i     (mix_x),
    .y_i     (mix_y),
    .done_o  (mix_done),
    .res_o   (mix_res)
  );

  assign fin_st    = short_path ? whmh_pkg::ST_FIN1 : whmh_pkg::ST_PREP;
  assign after_pre = full_q ? whmh_pkg::ST_BLK0 : (last_q ? fin_st : whmh_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      whmh_pkg::ST_IDLE: if (accept) state_d = whmh_pkg::ST_LOAD;
      whmh_pkg::ST_LOAD: state_d = pre_q ? whmh_pkg::ST_PRE : after_pre;
      whmh_pkg::ST_PRE:  if (mix_done) state_d = after_pre;
      whmh_pkg::ST_BLK0: if (mix_done) state_d = whmh_pkg::ST_BLK1;
      whmh_pkg::ST_BLK1: if (mix_done) state_d = whmh_pkg::ST_BLK2;
      whmh_pkg::ST_BLK2: begin
        if (mix_done) state_d = last_q ? fin_st : whmh_pkg::ST_IDLE;
      end
      whmh_pkg::ST_PREP: begin
        state_d = (rem_q > 6'd16) ? whmh_pkg::ST_TAIL : whmh_pkg::ST_FIN1;
      end
      whmh_pkg::ST_TAIL: if (mix_done) state_d = whmh_pkg::ST_FIN1;
      whmh_pkg::ST_FIN1: if (mix_done) state_d = whmh_pkg::ST_FIN2;
      whmh_pkg::ST_FIN2: if (mix_done) state_d = whmh_pkg::ST_OUT;
      whmh_pkg::ST_OUT: begin
        if (!out_valid_q || hash_o.ready) state_d = whmh_pkg::ST_IDLE;
      end
      default: state_d = whmh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= whmh_pkg::ST_IDLE;
      pend_q      <= 1'b0;
      slot_q      <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      c0_q        <= '0;
      c1_q        <= '0;
      c2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mix_start) begin
        pend_q <= 1'b1;
      end else if (mix_done) begin
        pend_q <= 1'b0;
      end
      if (out_valid_q && hash_o.ready
          && !(state_q == whmh_pkg::ST_OUT && state_d == whmh_pkg::ST_IDLE)) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        slot_q <= (n_in == 4'd8 && slot_in == 3'd5) ? 3'd0 : slot_in + 3'd1;
        if (len_sum[LENGTH_BITS]) begin
          len_q <= '1;
          ovf_q <= 1'b1;
        end else begin
          len_q <= len_sum[LENGTH_BITS-1:0];
        end
      end
      if (mix_done) begin
        case (state_q)
          whmh_pkg::ST_PRE: begin
            c0_q <= seed_q ^ mix_res;
            c1_q <= seed_q ^ mix_res;
            c2_q <= seed_q ^ mix_res;
          end
          whmh_pkg::ST_BLK0, whmh_pkg::ST_TAIL: c0_q <= mix_res;
          whmh_pkg::ST_BLK1: c1_q <= mix_res;
          whmh_pkg::ST_BLK2: c2_q <= mix_res;
          default: ;
        endcase
      end
      if (state_q == whmh_pkg::ST_PREP) begin
        c0_q <= c0_q ^ c1_q;
        c2_q <= c2_q + c1_q;
      end
      if (state_q == whmh_pkg::ST_OUT && state_d == whmh_pkg::ST_IDLE) begin
        out_valid_q <= 1'b1;
        slot_q      <= '0;
        len_q       <= '0;
        ovf_q       <= 1'b0;
        c0_q        <= '0;
        c1_q        <= '0;
        c2_q        <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q[slot_in] <= word_in;
      prev_q        <= cur_q;
      cur_q         <= word_in;
      n_q           <= n_in;
      last_q        <= msg_i.last_word;
      full_q        <= (n_in == 4'd8) && (slot_in == 3'd5);
      rem_q         <= ((n_in == 4'd8) && (slot_in == 3'd5)) ? 6'd0
                     : {slot_in, 3'b000} + 6'(n_in);
      pre_q         <= (len_q == '0) && !ovf_q;
    end
    if (mix_done && (state_q == whmh_pkg::ST_FIN1 || state_q == whmh_pkg::ST_FIN2)) begin
      r_q <= mix_res;
    end
    if (state_q == whmh_pkg::ST_OUT && state_d == whmh_pkg::ST_IDLE) begin
      out_hash_q <= r_q;
      out_long_q <= ovf_q;
    end
  end

  assign hash_o.valid      = out_valid_q;
  assign hash_o.hash_value = out_hash_q;
  assign hash_o.too_long   = out_long_q;

endmodule

// File: rtl/whmh_checker.sv
// ----------------------------------------------------------------------------
// whmh_checker
// Port-level checks of the message hash unit, bound to the top level.
// ----------------------------------------------------------------------------
module whmh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_hash_i,
  input logic        out_long_i,
  input logic        pready_i
);

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("Configuration port is not ready.");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("An item was taken while the previous one was still in work.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("A stalled result was dropped.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_hash_i) && $stable(out_long_i))
    else $error("A stalled result changed.");

endmodule

bind wyhash_variant_message_hash_unit whmh_checker u_whmh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (msg_i.valid),
  .in_ready_i  (msg_i.ready),
  .out_valid_i (hash_o.valid),
  .out_ready_i (hash_o.ready),
  .out_hash_i  (hash_o.hash_value),
  .out_long_i  (hash_o.too_long),
  .pready_i    (pready)
);

// File: tb/tb_wyhash_variant_message_hash_unit.sv
// ----------------------------------------------------------------------------
// tb_wyhash_variant_message_hash_unit
// Streams directed and random-length messages through the hash unit, with random
// idle cycles for most of the run, predicts every hash with a bit-accurate model and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_wyhash_variant_message_hash_unit;

  typedef struct packed {
    logic [63:0] hash_value;
    logic        too_long;
  } hash_res_t;

  class hash_scoreboard;
    hash_res_t   pending_q[$];
    int          fail_cnt;
    logic [63:0] seed_val;
    logic [63:0] chn_a, chn_b, chn_c;
    logic [63:0] blk[6];
    int unsigned slot_nxt;
    logic [31:0] msg_len;
    logic        ovf;

    function void clear_msg();
      chn_a = '0; chn_b = '0; chn_c = '0;
      slot_nxt = 0; msg_len = '0; ovf = 1'b0;
    endfunction

    function void init();
      seed_val = '0;
      fail_cnt = 0;
      for (int i = 0; i < 6; i++) blk[i] = '0;
      clear_msg();
    endfunction

    function logic [63:0] mix(logic [63:0] x, logic [63:0] y);
      logic [127:0] p;
      p = 128'(x) * 128'(y);
      return p[127:64] ^ p[63:0];
    endfunction

    function logic [63:0] rd(int unsigned off, int unsigned nb, int unsigned lim);
      logic [63:0] v;
      int unsigned pos;
      v = '0;
      for (int unsigned k = 0; k < nb; k++) begin
        pos = off + k;
        if (pos < lim && pos < 48) v[8*k +: 8] = blk[pos/8][8*(pos%8) +: 8];
      end
      return v;
    endfunction

    function void note_word(logic [63:0] w, logic [3:0] bc, logic lw);
      int unsigned n, slot, rem, ln;
      logic [63:0] s, s1, s2, a, b, r, len;
      hash_res_t res;
      if (msg_len == 0 && !ovf) begin
        s = seed_val ^ mix(seed_val ^ whmh_pkg::MIX_K, seed_val);
        chn_a = s; chn_b = s; chn_c = s;
        slot_nxt = 0;
      end
      n = lw ? ((bc > 8) ? 8 : bc) : 8;
      if (n < 8) w = w & ((64'd1 << (8*n)) - 1);
      slot = (slot_nxt > 5) ? 0 : slot_nxt;
      blk[slot] = w;
      if (n > 32'hFFFF_FFFF - msg_len) begin
        msg_len = 32'hFFFF_FFFF;
        ovf = 1'b1;
      end else begin
        msg_len = msg_len + n;
      end
      if (n == 8 && slot == 5) begin
        s = mix(blk[0] ^ chn_a, blk[1] ^ chn_b);
        s1 = mix(blk[2] ^ chn_b, blk[3] ^ chn_c);
        s2 = mix(blk[4] ^ chn_c, blk[5] ^ s);
        chn_a = s; chn_b = s1; chn_c = s2;
        slot_nxt = 0;
        rem = 0;
      end else begin
        rem = slot*8 + n;
        slot_nxt = slot + 1;
      end
      if (!lw) return;
      len = 64'(msg_len);
      s = chn_a;
      if (len <= whmh_pkg::SHORT_MAX && !ovf) begin
        ln = int'(len);
        a = rd(0, 8, rem);
        if (ln <= 8) b = (len << 56) | (rd(0, 4, rem) << 16);
        else b = rd(8, 8, rem);
        if (ln >= 4 && ln <= 8) begin
          a = (rd(0, 4, rem) << 16) | ((ln <= 4) ? len : rd(ln - 4, 4, rem));
          a = a << 16;
          a = a | rd((ln >> 1) & 3, 4, rem);
        end
        r = mix(a ^ whmh_pkg::MIX_K, b ^ s);
        r = mix(r ^ len, s ^ whmh_pkg::MIX_K);
      end else begin
        s1 = chn_b;
        s2 = chn_c;
        s = s ^ s1;
        s2 = s2 + s1;
        if (rem <= 16) begin
          a = (rem >= 8) ? rd(0, 8, rem) : 64'(rem);
          b = (rem >= 8) ? rd(rem - 8, 8, rem) : 64'(rem);
        end else begin
          a = rd(0, 8, rem);
          b = rd(8, 8, rem);
          s = mix(a ^ s, b ^ s2);
          if (rem >= 24) begin
            a = rd(16, 8, rem);
            b = rd(rem - 8, 8, rem);
          end
        end
        r = mix(a ^ s, b ^ s2);
        r = mix(r ^ len, whmh_pkg::MIX_K);
      end
      res.hash_value = r;
      res.too_long = ovf;
      pending_q.push_back(res);
      clear_msg();
    endfunction

    function void check_hash(logic [63:0] hv, logic tl);
      hash_res_t e;
      if (pending_q.size() == 0) begin
        $error("Unexpected hash %h", hv);
        fail_cnt++;
        return;
      end
      e = pending_q.pop_front();
      if (hv !== e.hash_value) begin
        $error("hash_value expected %h actual %h", e.hash_value, hv);
        fail_cnt++;
      end
      if (tl !== e.too_long) begin
        $error("too_long expected %b actual %b", e.too_long, tl);
        fail_cnt++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [whmh_pkg::ADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;
  logic idle_on;
  int words_sent;

  whmh_in_if  msg_if ();
  whmh_out_if hash_if ();

  hash_scoreboard sb;

  wyhash_variant_message_hash_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if.sink),
    .hash_o (hash_if.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic write_seed(logic [63:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= whmh_pkg::ADDR_SEED; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.seed_val = v;
  endtask

  task automatic send_word(logic [63:0] w, logic [3:0] bc, logic lw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      msg_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    msg_if.valid <= 1'b1;
    msg_if.data_word <= w;
    msg_if.byte_count <= bc;
    msg_if.last_word <= lw;
    do @(posedge clk_i); while (!msg_if.ready);
    sb.note_word(w, bc, lw);
    words_sent++;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Full words are taken as eight bytes even if the count says otherwise.
  task automatic send_msg(int unsigned nbytes, logic junk_counts);
    int unsigned full;
    logic [3:0] tail;
    full = nbytes / 8;
    tail = 4'(nbytes % 8);
    if (tail == 0 && full > 0) begin
      full--;
      tail = 4'd8;
    end
    for (int unsigned i = 0; i < full; i++)
      send_word(rnd64(), junk_counts ? 4'($urandom) : 4'd8, 1'b0);
    if (junk_counts && tail == 4'd8 && $urandom_range(0, 1)) tail = 4'($urandom_range(9, 15));
    send_word(rnd64(), tail, 1'b1);
  endtask

  task automatic drain();
    msg_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    hash_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hash_if.valid && hash_if.ready) sb.check_hash(hash_if.hash_value, hash_if.too_long);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        hash_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) begin
          @(posedge clk_i);
        end
        hash_if.ready <= 1'b1;
      end else begin
        hash_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    sb.init();
    words_sent = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    msg_if.valid = 1'b0; msg_if.data_word = '0;
    msg_if.byte_count = '0; msg_if.last_word = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(rnd64(), 4'd0, 1'b1);
    for (int n = 1; n <= 17; n++) send_msg(n, 1'b0);
    send_msg(48, 1'b0);
    send_msg(49, 1'b1);
    send_msg(95, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
    send_word('0, 4'd8, 1'b1);
    drain();
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    send_msg(7, 1'b0);
    send_msg(40, 1'b1);
    drain();
    write_seed(64'd0);
    send_msg(24, 1'b0);
    drain();
    write_seed(rnd64());

    while (words_sent < 550) begin
      if (words_sent > 450) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        drain();
        write_seed(rnd64());
      end
      case ($urandom_range(0, 3))
        0: send_msg($urandom_range(0, 16), $urandom_range(0, 1));
        1: send_msg($urandom_range(17, 48), $urandom_range(0, 1));
        2: send_msg($urandom_range(49, 130), $urandom_range(0, 1));
        default: send_msg(48 * $urandom_range(1, 3), 1'b0);
      endcase
    end
    drain();
    if (sb.fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
